@@ design/hkset_pkg.sv @@
`default_nettype none

package hkset_pkg;

    // field widths
    localparam int KEY_W     = 64;
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 10;
    localparam int MASK_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int GROUP_N   = 4;

    // hash constants
    localparam int               XS_SHIFT       = 33;
    localparam logic [KEY_W-1:0] FACTOR_ONE_RST = 64'hA6C3096657A14E89;
    localparam logic [KEY_W-1:0] FACTOR_TWO_RST = 64'h24F963569D05D92E;
    localparam logic [MASK_W-1:0] MASK_RST      = 10'h3FC;
    localparam logic [MASK_W-1:0] MASK_KEEP     = 10'h3FC;

    // item commands
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    // insert status codes
    localparam logic [1:0] ST_INSERTED   = 2'd0;
    localparam logic [1:0] ST_DUPLICATE  = 2'd1;
    localparam logic [1:0] ST_GROUP_FULL = 2'd2;
    localparam logic [1:0] ST_ZERO_KEY   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_TWO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MASK = 2'd2;

    // partial product selects of the 64-bit multiply
    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_LH = 2'd1;
    localparam logic [1:0] PP_HL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic [1:0] pp_sel;
        logic       fac_two;
        logic       acc_set;
        logic       acc_add;
        logic       mix;
        logic       base_en;
        logic       quo_en;
        logic       slot_en;
        logic       rd_en;
        logic       rd_entry;
        logic [1:0] rd_sel;
        logic       clr_en;
        logic       ins_wr;
        logic       entry_wr;
        logic       res_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic             clr_last;
        logic             out_busy;
        logic [CMD_W-1:0] cmd;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ design/hkset_ctrl.sv @@
`default_nettype none

module hkset_ctrl
    import hkset_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_command,
    output logic             o_ready,
    output t_dp_cmd          o_dp_cmd,
    input  t_dp_sts          i_dp_sts
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_BASE  = 4'd3;
    localparam logic [3:0] S_QUO   = 4'd4;
    localparam logic [3:0] S_SLOT  = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_RWAIT = 4'd7;
    localparam logic [3:0] S_EXEC  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // steps of one 64-bit multiply round
    localparam logic [2:0] SUB_LL  = 3'd0;
    localparam logic [2:0] SUB_LH  = 3'd1;
    localparam logic [2:0] SUB_HL  = 3'd2;
    localparam logic [2:0] SUB_ACC = 3'd3;
    localparam logic [2:0] SUB_MIX = 3'd4;

    logic [3:0] r_state, n_state;
    logic [2:0] r_sub, n_sub;
    logic       r_round, n_round;
    logic [1:0] r_rdcnt, n_rdcnt;
    logic       r_clr_reply, n_clr_reply;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_sub       <= SUB_LL;
            r_round     <= 1'b0;
            r_rdcnt     <= 2'd0;
            r_clr_reply <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sub       <= n_sub;
            r_round     <= n_round;
            r_rdcnt     <= n_rdcnt;
            r_clr_reply <= n_clr_reply;
        end
    end

    // sequencing and datapath commands
    always_comb begin
        n_state     = r_state;
        n_sub       = r_sub;
        n_round     = r_round;
        n_rdcnt     = r_rdcnt;
        n_clr_reply = r_clr_reply;
        o_dp_cmd    = '0;
        o_ready     = (r_state == S_IDLE);

        case (r_state)
            S_CLR: begin
                o_dp_cmd.clr_en = 1'b1;
                if (i_dp_sts.clr_last) begin
                    n_state     = r_clr_reply ? S_DONE : S_IDLE;
                    n_clr_reply = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.capture = 1'b1;
                    n_sub   = SUB_LL;
                    n_round = 1'b0;
                    n_rdcnt = 2'd0;
                    case (i_command)
                        CMD_LOOKUP, CMD_INSERT: n_state = S_HASH;
                        CMD_CLEAR: begin
                            n_clr_reply = 1'b1;
                            n_state     = S_CLR;
                        end
                        CMD_WRITE: n_state = S_EXEC;
                        CMD_READ:  n_state = S_RD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_HASH: begin
                o_dp_cmd.fac_two = r_round;
                n_sub = r_sub + 3'd1;
                case (r_sub)
                    SUB_LL: begin
                        o_dp_cmd.mul_en = 1'b1;
                        o_dp_cmd.pp_sel = PP_LL;
                    end
                    SUB_LH: begin
                        o_dp_cmd.acc_set = 1'b1;
                        o_dp_cmd.mul_en  = 1'b1;
                        o_dp_cmd.pp_sel  = PP_LH;
                    end
                    SUB_HL: begin
                        o_dp_cmd.acc_add = 1'b1;
                        o_dp_cmd.mul_en  = 1'b1;
                        o_dp_cmd.pp_sel  = PP_HL;
                    end
                    SUB_ACC: begin
                        o_dp_cmd.acc_add = 1'b1;
                    end
                    SUB_MIX: begin
                        o_dp_cmd.mix = 1'b1;
                        n_sub = SUB_LL;
                        if (r_round) begin
                            n_state = S_BASE;
                        end else begin
                            n_round = 1'b1;
                        end
                    end
                    default: n_sub = SUB_LL;
                endcase
            end
            S_BASE: begin
                o_dp_cmd.base_en = 1'b1;
                n_state = S_QUO;
            end
            S_QUO: begin
                o_dp_cmd.quo_en = 1'b1;
                n_state = S_SLOT;
            end
            S_SLOT: begin
                o_dp_cmd.slot_en = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                o_dp_cmd.rd_en    = 1'b1;
                o_dp_cmd.rd_sel   = r_rdcnt;
                o_dp_cmd.rd_entry = (i_dp_sts.cmd == CMD_READ);
                if (o_dp_cmd.rd_entry || (&r_rdcnt)) begin
                    n_state = S_RWAIT;
                end else begin
                    n_rdcnt = r_rdcnt + 2'd1;
                end
            end
            S_RWAIT: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_dp_cmd.ins_wr   = (i_dp_sts.cmd == CMD_INSERT);
                o_dp_cmd.entry_wr = (i_dp_sts.cmd == CMD_WRITE);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_dp_sts.out_busy) begin
                    o_dp_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ design/hkset_dp.sv @@
`default_nettype none

module hkset_dp
    import hkset_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [IDX_W-1:0]     i_entry_index,
    input  logic [KEY_W-1:0]     i_entry_data,
    input  t_dp_cmd              i_dp_cmd,
    output t_dp_sts              o_dp_sts,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_found,
    output logic [1:0]           o_insert_status,
    output logic [KEY_W-1:0]     o_read_data
);

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int AW1       = AW + 1;
    localparam int MOD_SHIFT = 24;
    localparam int RECIP     = (1 << MOD_SHIFT) / TABLE_DEPTH + 1;
    localparam int QPW       = MOD_SHIFT + MASK_W;

    // configuration registers
    logic [KEY_W-1:0]  r_fac_one;
    logic [KEY_W-1:0]  r_fac_two;
    logic [MASK_W-1:0] r_mask;

    // captured item
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_idx;
    logic [KEY_W-1:0] r_data;

    // hash and group index
    logic [KEY_W-1:0]  r_x;
    logic [KEY_W-1:0]  r_prod;
    logic [KEY_W-1:0]  r_acc;
    logic [MASK_W-1:0] r_base;
    logic [MASK_W-1:0] r_quo;
    logic [AW-1:0]     r_slot0;

    // table and group read-back
    logic [KEY_W-1:0] r_table [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rdata;
    logic             r_rd_pend;
    logic [1:0]       r_rd_tag;
    logic [KEY_W-1:0] r_grp [GROUP_N];
    logic [AW-1:0]    r_clr_pos;

    // result register
    logic             r_out_valid;
    logic             r_found;
    logic [1:0]       r_status;
    logic [KEY_W-1:0] r_read;

    logic [KEY_W-1:0] fac;
    logic [31:0]      pp_a;
    logic [31:0]      pp_b;
    logic [QPW-1:0]   quo_prod;
    logic [31:0]      rem_full;
    logic [GROUP_N-1:0] hit;
    logic [GROUP_N-1:0] zero;
    logic [1:0]       empty_sel;
    logic             key_zero;
    logic             dup;
    logic             has_empty;
    logic             ins_ok;
    logic             idx_ok;
    logic [1:0]       ins_status;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr;

    // entry number of one member of the group, wrapping at the table end
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] first,
                                              input logic [1:0] off);
        logic [AW1-1:0] sum;
        sum = {1'b0, first} + AW1'(off);
        if (sum >= AW1'(TABLE_DEPTH)) begin
            sum = sum - AW1'(TABLE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fac_one <= FACTOR_ONE_RST;
            r_fac_two <= FACTOR_TWO_RST;
            r_mask    <= MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FACTOR_ONE: r_fac_one <= i_cfg_data;
                CFG_FACTOR_TWO: r_fac_two <= i_cfg_data;
                CFG_GROUP_MASK: r_mask    <= i_cfg_data[MASK_W-1:0] & MASK_KEEP;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd  <= i_command;
            r_key  <= i_key;
            r_idx  <= i_entry_index;
            r_data <= i_entry_data;
        end
    end

    // partial product operand select
    always_comb begin
        fac = i_dp_cmd.fac_two ? r_fac_two : r_fac_one;
        case (i_dp_cmd.pp_sel)
            PP_LH: begin
                pp_a = r_x[31:0];
                pp_b = fac[63:32];
            end
            PP_HL: begin
                pp_a = r_x[63:32];
                pp_b = fac[31:0];
            end
            default: begin
                pp_a = r_x[31:0];
                pp_b = fac[31:0];
            end
        endcase
    end

    // shared 32x32 multiplier, accumulator and xor-shift
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_x <= i_key ^ (i_key >> XS_SHIFT);
        end else if (i_dp_cmd.mix) begin
            r_x <= r_acc ^ (r_acc >> XS_SHIFT);
        end
        if (i_dp_cmd.mul_en) begin
            r_prod <= 64'(pp_a) * 64'(pp_b);
        end
        if (i_dp_cmd.acc_set) begin
            r_acc <= r_prod;
        end else if (i_dp_cmd.acc_add) begin
            r_acc <= r_acc + {r_prod[31:0], 32'b0};
        end
    end

    // group base modulo table depth by reciprocal multiply
    assign quo_prod = QPW'(r_base) * QPW'(RECIP);
    assign rem_full = 32'(r_base) - 32'(r_quo) * 32'(TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.base_en) begin
            r_base <= r_x[MASK_W-1:0] & r_mask;
        end
        if (i_dp_cmd.quo_en) begin
            r_quo <= quo_prod[MOD_SHIFT +: MASK_W];
        end
        if (i_dp_cmd.slot_en) begin
            r_slot0 <= rem_full[AW-1:0];
        end
    end

    // group compare and first empty entry
    always_comb begin
        for (int g = 0; g < GROUP_N; g++) begin
            hit[g]  = (r_grp[g] == r_key);
            zero[g] = (r_grp[g] == '0);
        end
        empty_sel = 2'd0;
        for (int g = GROUP_N - 1; g >= 0; g--) begin
            if (zero[g]) begin
                empty_sel = 2'(g);
            end
        end
    end

    assign key_zero  = (r_key == '0);
    assign dup       = |hit;
    assign has_empty = |zero;
    assign ins_ok    = !key_zero && !dup && has_empty;
    assign idx_ok    = (32'(r_idx) < 32'(TABLE_DEPTH));

    always_comb begin
        if (key_zero) begin
            ins_status = ST_ZERO_KEY;
        end else if (dup) begin
            ins_status = ST_DUPLICATE;
        end else if (has_empty) begin
            ins_status = ST_INSERTED;
        end else begin
            ins_status = ST_GROUP_FULL;
        end
    end

    // table write port select
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = r_clr_pos;
        wr_data = '0;
        if (i_dp_cmd.clr_en) begin
            mem_we = 1'b1;
        end else if (i_dp_cmd.ins_wr && ins_ok) begin
            mem_we  = 1'b1;
            wr_addr = slot_at(r_slot0, empty_sel);
            wr_data = r_key;
        end else if (i_dp_cmd.entry_wr && idx_ok) begin
            mem_we  = 1'b1;
            wr_addr = AW'(r_idx);
            wr_data = r_data;
        end
    end

    assign rd_addr = i_dp_cmd.rd_entry ? AW'(r_idx) : slot_at(r_slot0, i_dp_cmd.rd_sel);

    // key table, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[wr_addr] <= wr_data;
        end
        if (i_dp_cmd.rd_en) begin
            r_rdata <= r_table[rd_addr];
        end
    end

    // read-back into the group registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_dp_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.rd_en) begin
            r_rd_tag <= i_dp_cmd.rd_sel;
        end
        if (r_rd_pend) begin
            r_grp[r_rd_tag] <= r_rdata;
        end
    end

    // clear sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_pos <= '0;
        end else if (i_dp_cmd.clr_en) begin
            r_clr_pos <= o_dp_sts.clr_last ? '0 : r_clr_pos + AW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.res_load) begin
            r_found  <= (r_cmd == CMD_LOOKUP) && !key_zero && dup;
            r_status <= (r_cmd == CMD_INSERT) ? ins_status : ST_INSERTED;
            r_read   <= ((r_cmd == CMD_READ) && idx_ok) ? r_grp[0] : '0;
        end
    end

    assign o_dp_sts.clr_last = (r_clr_pos == AW'(TABLE_DEPTH - 1));
    assign o_dp_sts.out_busy = r_out_valid && !i_ready;
    assign o_dp_sts.cmd      = r_cmd;

    assign o_valid         = r_out_valid;
    assign o_found         = r_found;
    assign o_insert_status = r_status;
    assign o_read_data     = r_read;

endmodule

`default_nettype wire

@@ design/hashed_key_set_4way_groups.sv @@
// Set of nonzero 64-bit keys in a table of TABLE_DEPTH 64-bit entries (0 means empty).
// A key hashes by xor-shift-33 and two multiply rounds with the configurable factors; the
// hash ANDed with group_mask picks a group of four consecutive entries, wrapping at the
// table end. Commands: lookup, insert (inserted, duplicate, group full, zero key
// rejected), clear table, write entry and read entry; every item returns one result.
// Steps of lookup and insert: the two 64-bit products on one shared 32x32 multiplier
// at three partial products each, the group index (base, quotient, slot), four table
// reads and the wait for the last read data, then compare/write and result load. Read
// entry does one table read, write entry at most one table write, unknown commands go
// straight to the result, and clear sweeps the table with one entry written per cycle.
// A result still waiting in the output register holds the next one back. After reset
// the block sweeps the table to zero with o_ready held low; configuration writes are
// taken at any time. One item is worked at a time; the next is accepted as soon as a
// result sits in the output register.
`default_nettype none

module hashed_key_set_4way_groups
    import hkset_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [IDX_W-1:0]     i_entry_index,
    input  logic [KEY_W-1:0]     i_entry_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_found,
    output logic [1:0]           o_insert_status,
    output logic [KEY_W-1:0]     o_read_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    hkset_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .o_dp_cmd  (dp_cmd),
        .i_dp_sts  (dp_sts)
    );

    // hash, table and result register
    hkset_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_key           (i_key),
        .i_entry_index   (i_entry_index),
        .i_entry_data    (i_entry_data),
        .i_dp_cmd        (dp_cmd),
        .o_dp_sts        (dp_sts),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_found         (o_found),
        .o_insert_status (o_insert_status),
        .o_read_data     (o_read_data)
    );

endmodule

`default_nettype wire

@@ test/hkset_checker.sv @@
module hkset_checker
    import hkset_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [IDX_W-1:0]     i_entry_index,
    input  logic [KEY_W-1:0]     i_entry_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_found,
    input  logic [1:0]           i_insert_status,
    input  logic [KEY_W-1:0]     i_read_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic             found;
        logic [1:0]       status;
        logic [KEY_W-1:0] read_data;
    } set_reply_t;

    // own copy of the key table and the registers
    logic [KEY_W-1:0]  key_store [TABLE_DEPTH];
    logic [KEY_W-1:0]  factor_one;
    logic [KEY_W-1:0]  factor_two;
    logic [MASK_W-1:0] group_mask;
    set_reply_t        replies_due [$];
    int                fail_count;

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // xor-shift and two multiply rounds, products modulo 2^64
    function automatic logic [KEY_W-1:0] key_hash(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = k ^ (k >> XS_SHIFT);
        h = h * factor_one;
        h = h ^ (h >> XS_SHIFT);
        h = h * factor_two;
        h = h ^ (h >> XS_SHIFT);
        return h;
    endfunction

    // entry n of the key's group, wrapping at the table end
    function automatic int group_slot(input logic [KEY_W-1:0] k, input int n);
        logic [KEY_W-1:0]  h;
        logic [MASK_W-1:0] base;
        h    = key_hash(k);
        base = h[MASK_W-1:0] & group_mask;
        return (int'(base) + n) % TABLE_DEPTH;
    endfunction

    // work out the reply of one command and update the table
    function automatic set_reply_t apply_set_command(
        input logic [CMD_W-1:0] cmd,
        input logic [KEY_W-1:0] key,
        input logic [IDX_W-1:0] idx,
        input logic [KEY_W-1:0] data
    );
        set_reply_t       reply;
        logic [KEY_W-1:0] held;
        logic             dup;
        int               free_pos;
        int               n;
        reply    = '0;
        dup      = 1'b0;
        free_pos = -1;
        case (cmd)
            CMD_LOOKUP: begin
                if (key != '0) begin
                    for (n = 0; n < GROUP_N; n++) begin
                        if (key_store[group_slot(key, n)] == key) reply.found = 1'b1;
                    end
                end
            end
            CMD_INSERT: begin
                if (key == '0) begin
                    reply.status = ST_ZERO_KEY;
                end else begin
                    for (n = 0; n < GROUP_N; n++) begin
                        held = key_store[group_slot(key, n)];
                        if (held == key) dup = 1'b1;
                        else if (held == '0 && free_pos < 0) free_pos = n;
                    end
                    if (dup) begin
                        reply.status = ST_DUPLICATE;
                    end else if (free_pos >= 0) begin
                        key_store[group_slot(key, free_pos)] = key;
                        reply.status = ST_INSERTED;
                    end else begin
                        reply.status = ST_GROUP_FULL;
                    end
                end
            end
            CMD_CLEAR: begin
                for (n = 0; n < TABLE_DEPTH; n++) key_store[n] = '0;
            end
            CMD_WRITE: begin
                if (int'(idx) < TABLE_DEPTH) key_store[idx] = data;
            end
            CMD_READ: begin
                if (int'(idx) < TABLE_DEPTH) reply.read_data = key_store[idx];
            end
            default: begin
                reply = '0;
            end
        endcase
        return reply;
    endfunction

    // watch both channels and the register port
    always @(posedge i_clk) begin : watch
        set_reply_t due;
        int         n;
        if (!i_rst_n) begin
            for (n = 0; n < TABLE_DEPTH; n++) key_store[n] = '0;
            factor_one = FACTOR_ONE_RST;
            factor_two = FACTOR_TWO_RST;
            group_mask = MASK_RST;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FACTOR_ONE: factor_one = i_cfg_data;
                    CFG_FACTOR_TWO: factor_two = i_cfg_data;
                    CFG_GROUP_MASK: group_mask = i_cfg_data[MASK_W-1:0] & MASK_KEEP;
                    default: ;
                endcase
            end
            // oldest reply first, then the item taken at this edge
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: reply with none due: found %0d status %0d read_data %h",
                                 $realtime, i_found, i_insert_status, i_read_data);
                end else begin
                    due = replies_due.pop_front();
                    if (due.found !== i_found || due.status !== i_insert_status ||
                        due.read_data !== i_read_data) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("%0t: wrong reply: found exp %0d got %0d, status exp %0d got %0d",
                                     $realtime, due.found, i_found, due.status, i_insert_status);
                            $display("    read_data exp %h got %h", due.read_data, i_read_data);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                replies_due.push_back(apply_set_command(i_command, i_key, i_entry_index,
                                                        i_entry_data));
        end
        o_fail_count <= fail_count;
        o_pending    <= replies_due.size();
    end

endmodule

@@ test/hashed_key_set_4way_groups_tb.sv @@
module hashed_key_set_4way_groups_tb;
    import hkset_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               CYCLE_LIMIT    = 1000000;
    localparam int               SETTLE_CYCLES  = 25;
    localparam int               PHASE_ITEMS    = 125;
    localparam int               POOL_SIZE      = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic [CMD_W-1:0]     i_command     = CMD_LOOKUP;
    logic [KEY_W-1:0]     i_key         = '0;
    logic [IDX_W-1:0]     i_entry_index = '0;
    logic [KEY_W-1:0]     i_entry_data  = '0;
    logic                 i_ready       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_FACTOR_ONE;
    logic [KEY_W-1:0]     i_cfg_data    = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_found;
    logic [1:0]           o_insert_status;
    logic [KEY_W-1:0]     o_read_data;

    int                   fail_count;
    int                   pending;
    int                   idle_pct    = 0;
    int                   stall_pct   = 0;
    int                   index_span  = 1024;
    int unsigned          cycle_count = 0;
    logic [KEY_W-1:0]     key_pool [POOL_SIZE];

    hashed_key_set_4way_groups u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_key           (i_key),
        .i_entry_index   (i_entry_index),
        .i_entry_data    (i_entry_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_found         (o_found),
        .o_insert_status (o_insert_status),
        .o_read_data     (o_read_data),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    hkset_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_command       (i_command),
        .i_key           (i_key),
        .i_entry_index   (i_entry_index),
        .i_entry_data    (i_entry_data),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_found         (o_found),
        .i_insert_status (o_insert_status),
        .i_read_data     (o_read_data),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("hashed_key_set_4way_groups: mismatch");
        $finish;
    end

    // random idle stretch before an item
    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // offer one item and hold it until taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        sender_gap();
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_key         <= key;
        i_entry_index <= idx;
        i_entry_data  <= data;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop sending until every reply has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [KEY_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // new register setting once the block is idle
    task automatic configure(input logic [KEY_W-1:0] f1, input logic [KEY_W-1:0] f2,
                             input logic [MASK_W-1:0] mask);
        logic [KEY_W-1:0] mask_word;
        mask_word             = {$urandom(), $urandom()};
        mask_word[MASK_W-1:0] = mask;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_FACTOR_ONE, f1);
        write_reg(CFG_FACTOR_TWO, f2);
        write_reg(CFG_GROUP_MASK, mask_word);
        write_reg(CFG_SPARE, {$urandom(), $urandom()});
        index_span = int'(mask & MASK_KEEP) + GROUP_N;
    endtask

    // keys reused within a phase so that hits and full groups occur
    task automatic refresh_pool();
        int n;
        for (n = 0; n < POOL_SIZE; n++) begin
            case ($urandom_range(3))
                0: key_pool[n] = KEY_W'($urandom_range(4095));
                1: key_pool[n] = {$urandom(), 32'h0} | KEY_W'($urandom_range(255));
                default: key_pool[n] = {$urandom(), $urandom()};
            endcase
        end
        key_pool[0]           = '1;
        key_pool[POOL_SIZE-1] = '0;
    endtask

    // one random item, mostly well-formed set traffic
    task automatic send_random_item();
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] data;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99);
        key  = key_pool[$urandom_range(POOL_SIZE-1)];
        data = {$urandom(), $urandom()};
        if ($urandom_range(9) < 7) idx = IDX_W'($urandom_range(index_span - 1));
        else idx = IDX_W'($urandom());
        if (pick < 34) begin
            cmd = CMD_LOOKUP;
            if ($urandom_range(4) == 0) key = {$urandom(), $urandom()};
        end else if (pick < 68) begin
            cmd = CMD_INSERT;
            if ($urandom_range(9) == 0) key = {$urandom(), $urandom()};
        end else if (pick < 80) begin
            cmd = CMD_READ;
        end else if (pick < 90) begin
            cmd = CMD_WRITE;
            case ($urandom_range(4))
                0, 1: data = key;
                2: data = '0;
                default: ;
            endcase
        end else if (pick < 92) begin
            cmd = CMD_CLEAR;
        end else if (pick < 96) begin
            cmd = CMD_W'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
        end else begin
            // noise over every field
            cmd = CMD_W'($urandom());
            key = {$urandom(), $urandom()};
            idx = IDX_W'($urandom());
        end
        send_item(cmd, key, idx, data);
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [KEY_W-1:0] f1,
                             input logic [KEY_W-1:0] f2, input logic [MASK_W-1:0] mask,
                             input int pause_at);
        int n;
        configure(f1, f2, mask);
        refresh_pool();
        idle_pct  = idle;
        stall_pct = stall;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == pause_at) drain();
            send_random_item();
        end
    endtask

    initial begin : stimulus
        int c;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero key, all-ones key, entry access, unknown codes, clear
        send_item(CMD_INSERT, '0, '0, '0);
        send_item(CMD_LOOKUP, '0, '0, '0);
        send_item(CMD_INSERT, '1, '0, '0);
        send_item(CMD_LOOKUP, '1, '1, '1);
        send_item(CMD_INSERT, '1, '0, '0);
        send_item(CMD_READ, '0, '0, '0);
        send_item(CMD_READ, '0, '1, '0);
        send_item(CMD_WRITE, '0, '1, '1);
        send_item(CMD_READ, '1, '1, '0);
        for (c = int'(CMD_UNKNOWN_LO); c <= int'(CMD_UNKNOWN_HI); c++)
            send_item(CMD_W'(c), {$urandom(), $urandom()}, IDX_W'($urandom()),
                      {$urandom(), $urandom()});
        send_item(CMD_CLEAR, '1, '1, '1);
        send_item(CMD_READ, '0, '1, '0);
        send_item(CMD_LOOKUP, '1, '0, '0);

        // unit factors: small keys hash to themselves, so groups are known
        configure(64'd1, 64'd1, '1);
        send_item(CMD_INSERT, 64'd4, '0, '0);
        send_item(CMD_INSERT, 64'd5, '0, '0);
        send_item(CMD_INSERT, 64'd6, '0, '0);
        send_item(CMD_INSERT, 64'd7, '0, '0);
        send_item(CMD_INSERT, 64'd1028, '0, '0);
        send_item(CMD_INSERT, 64'd5, '0, '0);
        send_item(CMD_LOOKUP, 64'd1028, '0, '0);
        // hole in a full group takes the next insert
        send_item(CMD_WRITE, '0, 10'd5, '0);
        send_item(CMD_INSERT, 64'd1028, '0, '0);
        send_item(CMD_READ, '0, 10'd5, '0);
        // loaded value is found by lookup
        send_item(CMD_WRITE, '0, 10'd8, 64'd9);
        send_item(CMD_LOOKUP, 64'd9, '0, '0);

        // random phases over idling patterns and register settings
        run_phase(0, 0, FACTOR_ONE_RST, FACTOR_TWO_RST, 10'h3FC, -1);
        run_phase(66, 0, {$urandom(), $urandom()}, {$urandom(), $urandom()}, 10'h00C, 60);
        run_phase(0, 66, '1, '1, 10'h000, -1);
        run_phase(34, 34, '0, '1, 10'h3FF, -1);
        run_phase(0, 0, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  MASK_W'($urandom()), -1);
        run_phase(66, 0, {$urandom(), $urandom()}, {$urandom(), $urandom()}, 10'h01C, -1);
        run_phase(0, 66, {$urandom(), $urandom()}, {$urandom(), $urandom()}, 10'h3FC, -1);
        run_phase(34, 34, 64'd1, 64'd1, 10'h0FC, -1);

        // wait out the last replies
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("hashed_key_set_4way_groups: match");
        end else begin
            $display("hashed_key_set_4way_groups: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/hkset_pkg.sv
design/hkset_ctrl.sv
design/hkset_dp.sv
design/hashed_key_set_4way_groups.sv
test/hkset_checker.sv
test/hashed_key_set_4way_groups_tb.sv
